// ----- rtl/rdsps_pkg.sv -----
// Package for the RDS type 0A group sequencer: sizes, AF codes, item kinds,
// configuration register indexes and the pipeline stage record.
// No dependencies.
package rdsps_pkg;

  // AF table geometry.
  localparam int AF_TABLE_DEPTH = 32;
  localparam int AF_ADDR_W      = $clog2(AF_TABLE_DEPTH);
  localparam int AF_POS_W       = 6;
  localparam int AF_IDX_W       = 5;
  localparam int AF_CODE_W      = 8;
  localparam int AF_COUNT_W     = 5;
  // Positions compared against the depth carry one extra bit.
  localparam int AF_POSX_W      = AF_POS_W + 1;
  localparam logic [AF_POSX_W-1:0] AF_DEPTH_POSX = AF_POSX_W'(AF_TABLE_DEPTH);

  // AF method A codes.
  localparam logic [AF_CODE_W-1:0] AF_LIST_BASE = 8'd224;
  localparam logic [AF_CODE_W-1:0] AF_PAD_CODE  = 8'd205;

  // Text geometry.
  localparam int TEXT_CHARS = 8;
  localparam int TEXT_W     = TEXT_CHARS * 8;
  localparam int SEG_W      = 2;

  // Port widths.
  localparam int BLOCK_B_W   = 5;
  localparam int BLOCK_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = TEXT_W;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_NEXT_GROUP  = 2'd0,
    KIND_AF_WRITE    = 2'd1,
    KIND_PS_NEW      = 2'd2,
    KIND_TRAFFIC_NEW = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PS_CHARS         = 3'd0,
    CFG_TRAFFIC_CHARS    = 3'd1,
    CFG_TRAFFIC_ANNOUNCE = 3'd2,
    CFG_DYNAMIC_PTY      = 3'd3,
    CFG_AF_COUNT         = 3'd4,
    CFG_AF_ENTRY_TOTAL   = 3'd5
  } cfg_reg_t;

  // What block C carries for one group.
  typedef enum logic [1:0] {
    AF_NONE   = 2'd0,
    AF_HEADER = 2'd1,
    AF_PAIR   = 2'd2
  } af_mode_t;

  // Group fields held while the AF table read completes.
  typedef struct packed {
    logic [BLOCK_B_W-1:0] block_b_low;
    logic [BLOCK_W-1:0]   block_d;
    af_mode_t             mode;
    logic [AF_CODE_W-1:0] header;
    logic                 first_live;
    logic                 second_live;
  } grp_stage_t;

endpackage

// ----- rtl/rdsps_in_if.sv -----
// Input channel of the RDS group sequencer: valid/ready handshake with the
// item payload. Depends on rdsps_pkg.
interface rdsps_in_if;
  import rdsps_pkg::*;

  logic                valid;
  logic                ready;
  kind_t               kind;
  logic [AF_IDX_W-1:0] af_index;
  logic [AF_CODE_W-1:0] af_value;

  modport source (output valid, output kind, output af_index, output af_value, input ready);
  modport sink (input valid, input kind, input af_index, input af_value, output ready);
endinterface

// ----- rtl/rdsps_out_if.sv -----
// Output channel of the RDS group sequencer: valid/ready handshake with the
// group block fields. Depends on rdsps_pkg.
interface rdsps_out_if;
  import rdsps_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BLOCK_B_W-1:0] block_b_low;
  logic [BLOCK_W-1:0]   block_c;
  logic [BLOCK_W-1:0]   block_d;

  modport source (output valid, output block_b_low, output block_c, output block_d,
                  input ready);
  modport sink (input valid, input block_b_low, input block_c, input block_d,
                output ready);
endinterface

// ----- rtl/rdsps_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module rdsps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rds_ps_group_with_af_sequencer_core.sv -----
// RDS type 0A group sequencer: builds block B low bits, the AF word of block C
// and the two characters of block D. Depends on rdsps_pkg, rdsps_in_if,
// rdsps_out_if and rdsps_ram.
//
// The block takes one item per clock cycle while the read stage is free or
// moving. A next-group beat passes the read stage, which holds it for the AF
// table read out of the synchronous RAM, then the output register. Other kinds
// (AF table write, new PS text, new traffic text) produce no result. The AF
// table is held as two identical RAM copies so both codes of a pair are read
// in the same cycle; per-entry valid bits make unwritten entries read as zero
// right after reset, with no clearing pass. The next beat is accepted while a
// finished group waits in the output register if the read stage is free.
// Configuration may be written only while no group is in flight.
module rds_ps_group_with_af_sequencer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rdsps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rdsps_pkg::CFG_DATA_W-1:0]  cfg_data,
  rdsps_in_if.sink                         item,
  rdsps_out_if.source                      result
);
  import rdsps_pkg::*;

  // Configuration registers.
  logic [TEXT_W-1:0]     ps_chars;
  logic [TEXT_W-1:0]     traffic_chars;
  logic                  traffic_announce;
  logic                  dynamic_pty;
  logic [AF_COUNT_W-1:0] af_count;
  logic [AF_POS_W-1:0]   af_entry_total;

  // Sequencer state.
  logic [SEG_W-1:0]      segment;
  logic [TEXT_W-1:0]     shown_ps;
  logic [TEXT_W-1:0]     shown_traffic;
  logic                  ps_pending;
  logic                  traffic_pending;
  logic [AF_POS_W-1:0]   af_position;
  logic [AF_POS_W-1:0]   af_position_next;
  logic [AF_TABLE_DEPTH-1:0] af_valid;

  // Handshake and pipeline.
  logic                  item_acc;
  logic                  grp_acc;
  logic                  afw_acc;
  logic                  s1_valid;
  logic                  s1_move;
  grp_stage_t            s1;
  grp_stage_t            s1_next;
  logic                  out_valid;
  logic [BLOCK_B_W-1:0]  out_b;
  logic [BLOCK_W-1:0]    out_c;
  logic [BLOCK_W-1:0]    out_d;

  // Datapath signals.
  logic [TEXT_W-1:0]     ps_eff;
  logic [TEXT_W-1:0]     traffic_eff;
  logic [TEXT_W-1:0]     text;
  logic [AF_POS_W-1:0]   pos_step;
  logic [AF_POSX_W-1:0]  pos_a;
  logic [AF_POSX_W-1:0]  pos_b;
  logic                  a_ok;
  logic                  b_ok;
  logic [AF_ADDR_W-1:0]  addr_a;
  logic [AF_ADDR_W-1:0]  addr_b;
  logic [AF_POSX_W-1:0]  widx;
  logic                  wr_ok;
  logic [AF_ADDR_W-1:0]  waddr;
  logic                  wr_en;
  logic [AF_CODE_W-1:0]  ram_a_q;
  logic [AF_CODE_W-1:0]  ram_b_q;
  logic [AF_CODE_W-1:0]  first_code;
  logic [AF_CODE_W-1:0]  second_raw;
  logic [AF_CODE_W-1:0]  second_code;
  logic [BLOCK_W-1:0]    block_c;

  // Beat acceptance; a new beat enters while the first stage is free or moving.
  assign s1_move    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || !out_valid || result.ready;
  assign item_acc   = item.valid && item.ready;
  assign grp_acc    = item_acc && (item.kind == KIND_NEXT_GROUP);
  assign afw_acc    = item_acc && (item.kind == KIND_AF_WRITE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ps_chars         <= 64'h2020_2020_2020_2020;
      traffic_chars    <= '0;
      traffic_announce <= 1'b0;
      dynamic_pty      <= 1'b0;
      af_count         <= '0;
      af_entry_total   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PS_CHARS:         ps_chars         <= cfg_data;
        CFG_TRAFFIC_CHARS:    traffic_chars    <= cfg_data;
        CFG_TRAFFIC_ANNOUNCE: traffic_announce <= cfg_data[0];
        CFG_DYNAMIC_PTY:      dynamic_pty      <= cfg_data[0];
        CFG_AF_COUNT:         af_count         <= cfg_data[AF_COUNT_W-1:0];
        CFG_AF_ENTRY_TOTAL:   af_entry_total   <= cfg_data[AF_POS_W-1:0];
        default: ;
      endcase
    end
  end

  // AF table write address; indexes beyond the table are dropped.
  assign widx  = AF_POSX_W'(item.af_index);
  assign wr_ok = widx < AF_DEPTH_POSX;
  assign waddr = widx[AF_ADDR_W-1:0];
  assign wr_en = afw_acc && wr_ok;

  // AF read positions for this group: the header reads entry zero through port A.
  assign pos_a  = AF_POSX_W'(af_position);
  assign pos_b  = pos_a + AF_POSX_W'(1);
  assign a_ok   = pos_a < AF_DEPTH_POSX;
  assign b_ok   = pos_b < AF_DEPTH_POSX;
  assign addr_a = pos_a[AF_ADDR_W-1:0];
  assign addr_b = pos_b[AF_ADDR_W-1:0];

  // Position advance after a header or a pair, with wrap to the header.
  always_comb begin
    pos_step = (af_position == '0) ? AF_POS_W'(1) : af_position + AF_POS_W'(2);
    if (af_count == '0) begin
      af_position_next = af_position;
    end else if (pos_step >= af_entry_total) begin
      af_position_next = '0;
    end else begin
      af_position_next = pos_step;
    end
  end

  // Text latched at segment zero when a reload is pending, and the shown text.
  always_comb begin
    ps_eff      = (segment == '0 && ps_pending) ? ps_chars : shown_ps;
    traffic_eff = (segment == '0 && traffic_pending) ? traffic_chars : shown_traffic;
    if (traffic_announce && traffic_eff[TEXT_W-1 -: 8] != '0) begin
      text = traffic_eff;
    end else begin
      text = ps_eff;
    end
  end

  // Group fields formed at acceptance.
  always_comb begin
    s1_next             = s1;
    s1_next.block_b_low = {traffic_announce, 1'b0,
                           (segment == '0) ? dynamic_pty : 1'b0, segment};
    case (segment)
      2'd0:    s1_next.block_d = text[TEXT_W-1  -: BLOCK_W];
      2'd1:    s1_next.block_d = text[TEXT_W-17 -: BLOCK_W];
      2'd2:    s1_next.block_d = text[TEXT_W-33 -: BLOCK_W];
      default: s1_next.block_d = text[TEXT_W-49 -: BLOCK_W];
    endcase
    if (af_count == '0) begin
      s1_next.mode = AF_NONE;
    end else if (af_position == '0) begin
      s1_next.mode = AF_HEADER;
    end else begin
      s1_next.mode = AF_PAIR;
    end
    s1_next.header      = AF_LIST_BASE + AF_CODE_W'(af_count);
    s1_next.first_live  = a_ok && af_valid[addr_a];
    s1_next.second_live = b_ok && af_valid[addr_b];
  end

  // Sequencer state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      segment         <= '0;
      shown_ps        <= '0;
      shown_traffic   <= '0;
      ps_pending      <= 1'b1;
      traffic_pending <= 1'b1;
      af_position     <= '0;
      af_valid        <= '0;
    end else begin
      if (grp_acc) begin
        segment     <= segment + SEG_W'(1);
        shown_ps    <= ps_eff;
        shown_traffic <= traffic_eff;
        af_position <= af_position_next;
        if (segment == '0) begin
          ps_pending      <= 1'b0;
          traffic_pending <= 1'b0;
        end
      end
      if (item_acc && item.kind == KIND_PS_NEW) begin
        ps_pending <= 1'b1;
      end
      if (item_acc && item.kind == KIND_TRAFFIC_NEW) begin
        traffic_pending <= 1'b1;
      end
      if (wr_en) begin
        af_valid[waddr] <= 1'b1;
      end
    end
  end

  // Two copies of the AF table so both codes of a pair read in the same cycle.
  rdsps_ram #(
    .WIDTH (AF_CODE_W),
    .DEPTH (AF_TABLE_DEPTH)
  ) u_af_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (item.af_value),
    .re    (grp_acc),
    .raddr (addr_a),
    .rdata (ram_a_q)
  );

  rdsps_ram #(
    .WIDTH (AF_CODE_W),
    .DEPTH (AF_TABLE_DEPTH)
  ) u_af_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (item.af_value),
    .re    (grp_acc),
    .raddr (addr_b),
    .rdata (ram_b_q)
  );

  // Read stage: group fields wait here for the RAM data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (grp_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_acc) begin
      s1 <= s1_next;
    end
  end

  // Block C from the table codes; an empty second code becomes the filler.
  always_comb begin
    first_code  = s1.first_live ? ram_a_q : '0;
    second_raw  = s1.second_live ? ram_b_q : '0;
    second_code = (second_raw == '0) ? AF_PAD_CODE : second_raw;
    case (s1.mode)
      AF_HEADER: block_c = {s1.header, first_code};
      AF_PAIR:   block_c = {first_code, second_code};
      default:   block_c = {AF_LIST_BASE, AF_PAD_CODE};
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_b <= s1.block_b_low;
      out_c <= block_c;
      out_d <= s1.block_d;
    end
  end

  assign result.valid       = out_valid;
  assign result.block_b_low = out_b;
  assign result.block_c     = out_c;
  assign result.block_d     = out_d;

  // A group beat always lands in the read stage.
  a_grp_enters: assert property (@(posedge clk) disable iff (rst)
    grp_acc |=> s1_valid)
    else $error("group beat did not enter the read stage");

  // The segment counter steps by one for each group.
  a_seg_step: assert property (@(posedge clk) disable iff (rst)
    grp_acc |=> segment == $past(segment) + SEG_W'(1))
    else $error("segment counter did not advance");

  // A segment-zero group consumes both pending reloads.
  a_reload_done: assert property (@(posedge clk) disable iff (rst)
    grp_acc && segment == '0 |=> !ps_pending && !traffic_pending)
    else $error("text reload still pending after segment zero");

  // After an AF step the position is the header or below the entry total.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    grp_acc && af_count != '0 |=>
      af_position == '0 || af_position < $past(af_entry_total))
    else $error("AF position beyond entry total");

  // A held read-stage group is never dropped while the output stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1))
    else $error("read stage lost a group under stall");

endmodule
